/* src/crpi_pkg.sv */
// ----------------------------------------------------------------------------
// crpi_pkg
// Types and constants shared by the Catmull-Rom pose interpolator modules.
// ----------------------------------------------------------------------------
package crpi_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_PUSH_POS  = 2'd0;
  localparam logic [1:0] OP_PUSH_LOOK = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;

  // Pi scaled by 2^60, rounded down.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Unwrapped look angles grow by at most a few half turns past 32 bits.
  localparam int unsigned LW = 34;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] point_t;
  typedef logic signed [LW-1:0] angle_t;

  typedef struct packed {
    logic en;
    logic sel_ext;
  } cell_ctrl_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_T2   = 8'b0000_0010,
    S_T3   = 8'b0000_0100,
    S_UNW  = 8'b0000_1000,
    S_WAIT = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_ACC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

endpackage

/* src/crpi_if.sv */
// ----------------------------------------------------------------------------
// crpi_in_if / crpi_out_if
// Valid/ready channels for input items and interpolated poses.
// ----------------------------------------------------------------------------
interface crpi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] z_value;
  logic [16:0]        share_t;

  modport source (output valid, op, x_value, y_value, z_value, share_t, input ready);
  modport sink (input valid, op, x_value, y_value, z_value, share_t, output ready);
endinterface

interface crpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] look_x;
  logic signed [31:0] look_y;
  logic signed [31:0] look_z;

  modport source (output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, look_x, look_y, look_z, output ready);
endinterface

/* src/crpi_cell.sv */
// ----------------------------------------------------------------------------
// crpi_cell
// One control point of a window. Loads either its neighbor or a new point.
// ----------------------------------------------------------------------------
module crpi_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crpi_pkg::cell_ctrl_t ctrl_i,
  input  crpi_pkg::point_t     nbr_i,
  input  crpi_pkg::point_t     ext_i,
  output crpi_pkg::point_t     q_o
);
  import crpi_pkg::*;

  point_t pt_q, pt_d;

  always_comb begin
    pt_d = pt_q;
    if (ctrl_i.en) begin
      pt_d = ctrl_i.sel_ext ? ext_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= '0;
    end else begin
      pt_q <= pt_d;
    end
  end

  assign q_o = pt_q;
endmodule

/* src/crpi_unwrap.sv */
// ----------------------------------------------------------------------------
// crpi_unwrap
// Brings an angle to within half a turn of the previous one. The turn count
// is estimated with a constant reciprocal and corrected by one compare and
// subtract.
// ----------------------------------------------------------------------------
module crpi_unwrap #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  crpi_pkg::coord_t    v_i,
  input  crpi_pkg::angle_t    prev_i,
  output logic                busy_o,
  output crpi_pkg::angle_t    res_o
);
  import crpi_pkg::*;

  localparam int unsigned DW = 36;
  localparam int unsigned RW = 34;
  localparam logic [63:0] PI_Q = (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [63:0] TURN_Q = PI_Q << 1;
  localparam logic signed [DW-1:0] PI_S = DW'(PI_Q);
  localparam logic [RW-1:0] TURN_R = RW'(TURN_Q);
  // A turn's reciprocal scaled by 2^RW; the quotient it gives is at most one low.
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << RW) / TURN_Q);

  logic            busy_q, busy_d;
  logic            neg_q, neg_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [RW-1:0]   r_q, r_d;
  logic [RW-1:0]   quo_q, quo_d;
  angle_t          prev_q, prev_d;
  angle_t          res_q, res_d;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] dp;
  logic [2*RW-1:0] recip_prod;
  logic [RW-1:0]   rem;

  always_comb begin
    diff       = DW'(v_i) - DW'(prev_i);
    recip_prod = (2 * RW)'(r_q) * (2 * RW)'(RECIP);
    rem        = (r_q >= TURN_R) ? r_q - TURN_R : r_q;
    if (neg_q) begin
      dp = (rem == '0) ? -PI_S : PI_S - $signed(DW'(rem));
    end else begin
      dp = (rem == '0) ? PI_S : $signed(DW'(rem)) - PI_S;
    end
  end

  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    quo_d  = quo_q;
    prev_d = prev_q;
    res_d  = res_q;
    if (start_i) begin
      prev_d = prev_i;
      cnt_d  = '0;
      if (diff > PI_S) begin
        busy_d = 1'b1;
        neg_d  = 1'b0;
        r_d    = RW'(diff - PI_S);
      end else if (diff < -PI_S) begin
        busy_d = 1'b1;
        neg_d  = 1'b1;
        r_d    = RW'(-diff - PI_S);
      end else begin
        res_d = LW'(v_i);
      end
    end else if (busy_q) begin
      case (cnt_q)
        2'd0: begin
          quo_d = recip_prod[2*RW-1:RW];
          cnt_d = 2'd1;
        end
        2'd1: begin
          r_d   = r_q - RW'(quo_q * TURN_R);
          cnt_d = 2'd2;
        end
        default: begin
          // Remainder known: place the difference in the half-turn interval.
          res_d  = LW'(DW'(prev_q) + dp);
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    r_q    <= r_d;
    quo_q  <= quo_d;
    prev_q <= prev_d;
    res_q  <= res_d;
  end

  assign busy_o = busy_q;
  assign res_o  = res_q;
endmodule

/* src/catmull_rom_pose_interpolator.sv */
// ----------------------------------------------------------------------------
// catmull_rom_pose_interpolator
// Catmull-Rom interpolation over a position window and a look-angle window.
// ----------------------------------------------------------------------------
// A push beat loads a new point into its window. An evaluate beat first forms
// the weights' powers of t, then for each of the four control points unwraps
// its look angles, multiplies and accumulates, and last forms the pose. The
// oldest look point is used as stored; each of the other three takes longer
// when one of its angles must be moved by whole turns. The points are visited
// by rotating each window, a row of four cells, once per point. One item is
// worked on at a time, and a finished pose may wait in the output register
// while further pushes are taken.
module catmull_rom_pose_interpolator #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned T_BITS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  crpi_in_if.sink    in_i,
  crpi_out_if.source out_o
);
  import crpi_pkg::*;

  localparam int unsigned TW = T_BITS + 1;
  localparam int unsigned CW = (TW > 17) ? TW : 17;
  localparam int unsigned WW = T_BITS + 5;
  localparam int unsigned PW = WW + LW;
  localparam int unsigned AW = PW + 2;
  localparam logic [CW-1:0] T_ONE = CW'(1) << T_BITS;

  state_e state_q, state_d;
  logic [1:0]   idx_q, idx_d;
  logic [TW-1:0] t_q, t_d, t2_q, t2_d, t3_q, t3_d;
  logic [2*TW:0] sq_full;
  logic signed [WW-1:0] tsv, t2s, t3s, w_sel;
  logic signed [PW-1:0] prod_p_q [3], prod_l_q [3];
  logic signed [AW-1:0] acc_p_q [3], acc_l_q [3];
  angle_t lprev_q [3];
  angle_t ures [3];
  logic [2:0] ubusy;
  logic ustart;
  logic [31:0] pout_q [3], lout_q [3];
  logic out_valid_q;
  logic [CW-1:0] share_ext;

  point_t pos_q [4], look_q [4];
  point_t new_pt;
  cell_ctrl_t pos_ctrl [4], look_ctrl [4];
  logic pos_push, look_push, rotate;
  logic in_acc;

  // Halves round towards plus infinity, then clamp to 32 bits.
  function automatic logic [31:0] sat_round(input logic signed [AW-1:0] acc);
    logic signed [AW:0] sh;
    sh = ((AW + 1)'(acc) + ((AW + 1)'(1) <<< T_BITS)) >>> (T_BITS + 1);
    if (sh > (AW + 1)'(32'sh7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end else if (sh < -(AW + 1)'(64'sh8000_0000)) begin
      return 32'h8000_0000;
    end
    return sh[31:0];
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign new_pt     = '{in_i.z_value, in_i.y_value, in_i.x_value};
  assign pos_push   = in_acc && (in_i.op == OP_PUSH_POS);
  assign look_push  = in_acc && (in_i.op == OP_PUSH_LOOK);
  assign rotate     = (state_q == S_ACC);

  // Each window is a row of cells; cell 0 holds the oldest point.
  for (genvar k = 0; k < 4; k++) begin : g_cells
    assign pos_ctrl[k]  = '{en: pos_push || rotate, sel_ext: (k == 3) && pos_push};
    assign look_ctrl[k] = '{en: look_push || rotate, sel_ext: (k == 3) && look_push};
    crpi_cell u_pos (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (pos_ctrl[k]),
      .nbr_i  (pos_q[(k + 1) % 4]),
      .ext_i  (new_pt),
      .q_o    (pos_q[k])
    );
    crpi_cell u_look (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (look_ctrl[k]),
      .nbr_i  (look_q[(k + 1) % 4]),
      .ext_i  (new_pt),
      .q_o    (look_q[k])
    );
  end

  assign ustart = (state_q == S_UNW);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    angle_t prev_sel;
    assign prev_sel = (idx_q == 2'd0) ? LW'(look_q[0][a]) : lprev_q[a];
    crpi_unwrap #(.FRAC_BITS(FRAC_BITS)) u_unwrap (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (ustart),
      .v_i     (look_q[0][a]),
      .prev_i  (prev_sel),
      .busy_o  (ubusy[a]),
      .res_o   (ures[a])
    );
  end

  // Weights, doubled, in Q(T_BITS).
  always_comb begin
    tsv = WW'(t_q);
    t2s = WW'(t2_q);
    t3s = WW'(t3_q);
    case (idx_q)
      2'd0:    w_sel = WW'(-tsv + 2 * t2s - t3s);
      2'd1:    w_sel = WW'(WW'(T_ONE) * 2 - 5 * t2s + 3 * t3s);
      2'd2:    w_sel = WW'(tsv + 4 * t2s - 3 * t3s);
      default: w_sel = t3s - t2s;
    endcase
  end

  always_comb begin
    share_ext = CW'(in_i.share_t);
    if (share_ext > T_ONE) begin
      t_d = TW'(T_ONE);
    end else begin
      t_d = TW'(share_ext);
    end
  end

  always_comb begin
    sq_full = (2 * TW + 1)'(state_q == S_T2 ? t_q * t_q : t2_q * t_q)
            + ((2 * TW + 1)'(1) << (T_BITS - 1));
    t2_d = TW'(sq_full >> T_BITS);
    t3_d = TW'(sq_full >> T_BITS);
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.op == OP_EVAL) begin
          state_d = S_T2;
        end
      end
      S_T2:   state_d = S_T3;
      S_T3:   state_d = S_UNW;
      S_UNW:  state_d = S_WAIT;
      S_WAIT: begin
        if (ubusy == 3'b000) begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        idx_d   = idx_q + 1'b1;
        state_d = (idx_q == 2'd3) ? S_OUT : S_UNW;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (state_q == S_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.op == OP_EVAL) begin
      t_q <= t_d;
    end
    if (state_q == S_T2) begin
      t2_q <= t2_d;
    end
    if (state_q == S_T3) begin
      t3_q <= t3_d;
    end
    for (int a = 0; a < 3; a++) begin
      if (state_q == S_MUL) begin
        prod_p_q[a] <= PW'(w_sel) * PW'(pos_q[0][a]);
        prod_l_q[a] <= PW'(w_sel) * PW'(ures[a]);
        lprev_q[a]  <= ures[a];
      end
      if (state_q == S_T2) begin
        acc_p_q[a] <= '0;
        acc_l_q[a] <= '0;
      end else if (state_q == S_ACC) begin
        acc_p_q[a] <= acc_p_q[a] + AW'(prod_p_q[a]);
        acc_l_q[a] <= acc_l_q[a] + AW'(prod_l_q[a]);
      end
      if (state_q == S_OUT && (!out_valid_q || out_o.ready)) begin
        pout_q[a] <= sat_round(acc_p_q[a]);
        lout_q[a] <= sat_round(acc_l_q[a]);
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.pos_x  = pout_q[0];
  assign out_o.pos_y  = pout_q[1];
  assign out_o.pos_z  = pout_q[2];
  assign out_o.look_x = lout_q[0];
  assign out_o.look_y = lout_q[1];
  assign out_o.look_z = lout_q[2];

  // A waiting pose holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.pos_x)
                                    && $stable(out_o.look_z))
    else $error("pending pose changed before it was taken");

  // The point index returns to zero whenever the block is idle.
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> idx_q == 2'd0)
    else $error("point index not zero in idle");

  // No unwrap is in flight once the weighted sum is being formed.
  a_unw_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL || state_q == S_IDLE |-> ubusy == 3'b000)
    else $error("unwrap still busy outside its wait");
endmodule
